[hw/rtl/fpia_pkg.sv]
`timescale 1ns / 1ps
// Shared types, operation and status codes, and fixed constants of the interval ALU.
// Depends on nothing; every other file of the block uses it.
package fpia_pkg;

   localparam int FRAC_BITS_DEFAULT = 48;
   localparam int MUL_LAT = 7;

   typedef enum logic [2:0] {
      ACT_ADD     = 3'd0,
      ACT_SUB     = 3'd1,
      ACT_MUL     = 3'd2,
      ACT_DIV     = 3'd3,
      ACT_SQRT    = 3'd4,
      ACT_OVERLAP = 3'd5
   } act_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_OVERFLOW   = 2'd1,
      ST_DIV_NONPOS = 2'd2,
      ST_ROOT_NEG   = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [63:0] a_low;
      logic signed [63:0] a_high;
      logic signed [63:0] b_low;
      logic signed [63:0] b_high;
   } req_type;

   typedef struct packed {
      logic signed [63:0] res_low;
      logic signed [63:0] res_high;
      logic               overlaps;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  action;
      logic        b_low_bad;
      logic        b_high_bad;
      logic        root_neg;
      logic [63:0] low;
      logic [63:0] high;
      logic        overlaps;
      logic [1:0]  status;
   } ctl_type;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
      logic        ovf;
   } mul_res_type;

   typedef struct packed {
      logic [63:0] root_low;
      logic [63:0] root_high;
      logic        inexact_high;
   } root_res_type;

endpackage

[hw/rtl/fpia_mul.sv]
`timescale 1ns / 1ps
// Seven-stage interval multiplier: four signed 64x64 products from 32-bit partial
// products, min and max over them, then floor and ceiling shift with range check.
module fpia_mul #(
   parameter int FRAC_BITS = fpia_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic [63:0] a_low,
   input  logic [63:0] a_high,
   input  logic [63:0] b_low,
   input  logic [63:0] b_high,
   output logic [63:0] low_out,
   output logic [63:0] high_out,
   output logic        ovf_out
);

   localparam logic [127:0] ROUND = (128'(1) << FRAC_BITS) - 128'(1);

   logic [63:0]  xa [0:3];
   logic [63:0]  ya [0:3];
   logic [63:0]  xm_ff [0:3];
   logic [63:0]  ym_ff [0:3];
   logic         sg1_ff [0:3];
   logic [63:0]  pp00_ff [0:3];
   logic [63:0]  pp01_ff [0:3];
   logic [63:0]  pp10_ff [0:3];
   logic [63:0]  pp11_ff [0:3];
   logic         sg2_ff [0:3];
   logic [127:0] sum_ff [0:3];
   logic         sg3_ff [0:3];
   logic [127:0] prod_ff [0:3];
   logic [127:0] mn01_ff, mn23_ff, mx01_ff, mx23_ff;
   logic [127:0] mn_ff, mx_ff;
   logic signed [127:0] f_val, c_val;
   logic [63:0]  low_ff, high_ff;
   logic         ovf_ff;

   assign xa[0] = a_low;
   assign xa[1] = a_low;
   assign xa[2] = a_high;
   assign xa[3] = a_high;
   assign ya[0] = b_low;
   assign ya[1] = b_high;
   assign ya[2] = b_low;
   assign ya[3] = b_high;

   for (genvar j = 0; j < 4; j++) begin : g_lane
      logic [64:0]  mid;
      logic [127:0] sum_in;
      always_comb begin
         mid    = {1'b0, pp01_ff[j]} + {1'b0, pp10_ff[j]};
         sum_in = {pp11_ff[j], pp00_ff[j]} + (128'(mid) << 32);
      end
      always_ff @(posedge clock) begin
         xm_ff[j]   <= xa[j][63] ? (~xa[j] + 64'd1) : xa[j];
         ym_ff[j]   <= ya[j][63] ? (~ya[j] + 64'd1) : ya[j];
         sg1_ff[j]  <= xa[j][63] ^ ya[j][63];
         pp00_ff[j] <= xm_ff[j][31:0] * ym_ff[j][31:0];
         pp01_ff[j] <= xm_ff[j][31:0] * ym_ff[j][63:32];
         pp10_ff[j] <= xm_ff[j][63:32] * ym_ff[j][31:0];
         pp11_ff[j] <= xm_ff[j][63:32] * ym_ff[j][63:32];
         sg2_ff[j]  <= sg1_ff[j];
         sum_ff[j]  <= sum_in;
         sg3_ff[j]  <= sg2_ff[j];
         prod_ff[j] <= sg3_ff[j] ? (~sum_ff[j] + 128'd1) : sum_ff[j];
      end
   end

   always_comb begin
      f_val = $signed(mn_ff) >>> FRAC_BITS;
      c_val = ($signed(mx_ff) + $signed(ROUND)) >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      mn01_ff  <= ($signed(prod_ff[1]) < $signed(prod_ff[0])) ? prod_ff[1] : prod_ff[0];
      mn23_ff  <= ($signed(prod_ff[3]) < $signed(prod_ff[2])) ? prod_ff[3] : prod_ff[2];
      mx01_ff  <= ($signed(prod_ff[0]) < $signed(prod_ff[1])) ? prod_ff[1] : prod_ff[0];
      mx23_ff  <= ($signed(prod_ff[2]) < $signed(prod_ff[3])) ? prod_ff[3] : prod_ff[2];
      mn_ff    <= ($signed(mn23_ff) < $signed(mn01_ff)) ? mn23_ff : mn01_ff;
      mx_ff    <= ($signed(mx01_ff) < $signed(mx23_ff)) ? mx23_ff : mx01_ff;
      low_ff   <= f_val[63:0];
      high_ff  <= c_val[63:0];
      ovf_ff   <= (f_val[127:63] != {65{f_val[63]}}) || (c_val[127:63] != {65{c_val[63]}});
   end

   assign low_out  = low_ff;
   assign high_out = high_ff;
   assign ovf_out  = ovf_ff;

endmodule

[hw/rtl/fpia_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, then floor and ceiling
// quotients of the scaled signed numerator with a 64-bit range check.
module fpia_div #(
   parameter int FRAC_BITS = fpia_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic [63:0] x_in,
   input  logic [63:0] y_in,
   output logic [63:0] floor_out,
   output logic [63:0] ceil_out,
   output logic        ovf_out
);

   localparam int QW = 64 + FRAC_BITS;
   localparam logic [QW:0] TOP = (QW + 1)'(1) << 63;

   logic [QW-1:0] m_ff   [0:QW-1];
   logic [63:0]   y_ff   [0:QW-1];
   logic [QW-1:0] q_ff   [0:QW];
   logic [63:0]   r_ff   [0:QW];
   logic          neg_ff [0:QW];
   logic [63:0]   mag_in;
   logic [QW:0]   q_ext, qp;
   logic          f_fit, c_fit;
   logic [63:0]   fl_in, ce_in;
   logic [63:0]   floor_ff, ceil_ff;
   logic          ovf_ff;

   assign mag_in = x_in[63] ? (~x_in + 64'd1) : x_in;

   always_ff @(posedge clock) begin
      m_ff[0]   <= {mag_in, {FRAC_BITS{1'b0}}};
      y_ff[0]   <= y_in;
      q_ff[0]   <= '0;
      r_ff[0]   <= '0;
      neg_ff[0] <= x_in[63];
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int BIT = QW - 1 - k;
      logic [64:0]   trial;
      logic [63:0]   r_in;
      logic [QW-1:0] q_in;
      always_comb begin
         trial = {r_ff[k], m_ff[k][BIT]};
         q_in  = q_ff[k];
         if (trial >= {1'b0, y_ff[k]}) begin
            r_in      = 64'(trial - {1'b0, y_ff[k]});
            q_in[BIT] = 1'b1;
         end else begin
            r_in = trial[63:0];
         end
      end
      always_ff @(posedge clock) begin
         q_ff[k+1]   <= q_in;
         r_ff[k+1]   <= r_in;
         neg_ff[k+1] <= neg_ff[k];
      end
      if (k < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            m_ff[k+1] <= m_ff[k];
            y_ff[k+1] <= y_ff[k];
         end
      end
   end

   always_comb begin
      q_ext = {1'b0, q_ff[QW]};
      qp    = q_ext + (QW + 1)'(|r_ff[QW]);
      if (neg_ff[QW]) begin
         fl_in = ~qp[63:0] + 64'd1;
         ce_in = ~q_ext[63:0] + 64'd1;
         f_fit = qp <= TOP;
         c_fit = q_ext <= TOP;
      end else begin
         fl_in = q_ext[63:0];
         ce_in = qp[63:0];
         f_fit = q_ext < TOP;
         c_fit = qp < TOP;
      end
   end

   always_ff @(posedge clock) begin
      floor_ff <= fl_in;
      ceil_ff  <= ce_in;
      ovf_ff   <= !(f_fit && c_fit);
   end

   assign floor_out = floor_ff;
   assign ceil_out  = ceil_ff;
   assign ovf_out   = ovf_ff;

endmodule

[hw/rtl/fpia_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root of a 64-bit value scaled by the
// fraction bits: two radicand bits per stage, with a flag for a nonzero remainder.
module fpia_sqrt #(
   parameter int FRAC_BITS = fpia_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic [63:0] x_in,
   output logic [63:0] root_out,
   output logic        inexact_out
);

   localparam int NW = 64 + FRAC_BITS;
   localparam int SW = (NW + 1) / 2;
   localparam int PW = 2 * SW;
   localparam int RW = SW + 2;

   logic [PW-1:0] n_ff    [0:SW-1];
   logic [SW-1:0] root_ff [0:SW];
   logic [RW-1:0] rem_ff  [0:SW];
   logic [63:0]   root_out_ff;
   logic          inexact_ff;

   always_ff @(posedge clock) begin
      n_ff[0]    <= PW'({x_in, {FRAC_BITS{1'b0}}});
      root_ff[0] <= '0;
      rem_ff[0]  <= '0;
   end

   for (genvar k = 0; k < SW; k++) begin : g_step
      localparam int PAIR = SW - 1 - k;
      logic [RW-1:0] shifted, trial, rem_in;
      logic [SW-1:0] root_in;
      logic          take;
      always_comb begin
         shifted = {rem_ff[k][RW-3:0], n_ff[k][2*PAIR+1 -: 2]};
         trial   = {root_ff[k], 2'b01};
         take    = shifted >= trial;
         rem_in  = take ? (shifted - trial) : shifted;
         root_in = {root_ff[k][SW-2:0], take};
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
      end
      if (k < SW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            n_ff[k+1] <= n_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      root_out_ff <= 64'(root_ff[SW]);
      inexact_ff  <= |rem_ff[SW];
   end

   assign root_out    = root_out_ff;
   assign inexact_out = inexact_ff;

endmodule

[hw/rtl/fixed_point_interval_alu.sv]
`timescale 1ns / 1ps
// Interval ALU top level: one request per cycle, busy stays low, results cannot be stalled.
// Latency is set by the divider chain of one quotient bit per stage; the other
// operations are delayed to match it.
// Throughput is one request per clock cycle.
// Synchronous reset clears all valid bits; requests in flight at reset are dropped.
module fixed_point_interval_alu #(
   parameter int FRAC_BITS = fpia_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fpia_pkg::req_type req_data,
   output logic             rsp_valid,
   output fpia_pkg::rsp_type rsp_data
);

   import fpia_pkg::*;

   localparam int DIV_LAT  = 64 + FRAC_BITS + 2;
   localparam int SQRT_LAT = (64 + FRAC_BITS + 1) / 2 + 2;
   localparam int LAT      = DIV_LAT + 1;
   localparam int MUL_PAD  = LAT - MUL_LAT;
   localparam int SQRT_PAD = LAT - SQRT_LAT;
   localparam logic [63:0] WORD_MIN = 64'h8000_0000_0000_0000;

   logic [LAT-1:0] vld_ff;
   ctl_type        ctl_in;
   ctl_type        ctl_ff [0:LAT-1];
   mul_res_type    mul_out;
   mul_res_type    mul_ff [0:MUL_PAD-1];
   root_res_type   root_out;
   root_res_type   root_ff [0:SQRT_PAD-1];
   logic [63:0]    dfl [0:3];
   logic [63:0]    dce [0:3];
   logic [3:0]     dovf;
   logic [63:0]    dmn01_ff, dmn23_ff, dmx01_ff, dmx23_ff;
   logic           dovf0_ff, dovf123_ff;
   logic [63:0]    sqrt_lo_x;
   logic           is_sub, neg_bad;
   logic [63:0]    bl_e, bh_e, ov_max, ov_min;
   logic [64:0]    sum_lo, sum_hi;
   rsp_type        rsp_in, rsp_ff;
   logic           rsp_valid_ff;
   ctl_type        c_last;

   assign busy = 1'b0;

   always_comb begin
      is_sub  = req_data.action == ACT_SUB;
      neg_bad = (req_data.b_low == WORD_MIN) || (req_data.b_high == WORD_MIN);
      bl_e    = is_sub ? (~req_data.b_high + 64'd1) : req_data.b_low;
      bh_e    = is_sub ? (~req_data.b_low + 64'd1) : req_data.b_high;
      sum_lo  = {req_data.a_low[63], req_data.a_low} + {bl_e[63], bl_e};
      sum_hi  = {req_data.a_high[63], req_data.a_high} + {bh_e[63], bh_e};
      ov_max  = (req_data.a_low < req_data.b_low) ? req_data.b_low : req_data.a_low;
      ov_min  = (req_data.a_high < req_data.b_high) ? req_data.a_high : req_data.b_high;
      ctl_in            = '0;
      ctl_in.action     = req_data.action;
      ctl_in.b_low_bad  = !(req_data.b_low > 64'sd0);
      ctl_in.b_high_bad = !(req_data.b_high > 64'sd0);
      ctl_in.root_neg   = req_data.a_high[63];
      if (req_data.action == ACT_ADD || req_data.action == ACT_SUB) begin
         if ((is_sub && neg_bad) || (sum_lo[64] != sum_lo[63])
             || (sum_hi[64] != sum_hi[63])) begin
            ctl_in.status = ST_OVERFLOW;
         end else begin
            ctl_in.low  = sum_lo[63:0];
            ctl_in.high = sum_hi[63:0];
         end
      end else if (req_data.action == ACT_OVERLAP) begin
         ctl_in.overlaps = !($signed(ov_min) < $signed(ov_max));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[LAT-2:0], start && !busy};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff[0] <= ctl_in;
      for (int k = 1; k < LAT; k++) begin
         ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   fpia_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock    (clock),
      .a_low    (req_data.a_low),
      .a_high   (req_data.a_high),
      .b_low    (req_data.b_low),
      .b_high   (req_data.b_high),
      .low_out  (mul_out.low),
      .high_out (mul_out.high),
      .ovf_out  (mul_out.ovf)
   );

   always_ff @(posedge clock) begin
      mul_ff[0] <= mul_out;
      for (int k = 1; k < MUL_PAD; k++) begin
         mul_ff[k] <= mul_ff[k-1];
      end
   end

   assign sqrt_lo_x = req_data.a_low[63] ? 64'd0 : req_data.a_low;

   fpia_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_lo (
      .clock       (clock),
      .x_in        (sqrt_lo_x),
      .root_out    (root_out.root_low),
      .inexact_out ()
   );

   fpia_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_hi (
      .clock       (clock),
      .x_in        (req_data.a_high),
      .root_out    (root_out.root_high),
      .inexact_out (root_out.inexact_high)
   );

   always_ff @(posedge clock) begin
      root_ff[0] <= root_out;
      for (int k = 1; k < SQRT_PAD; k++) begin
         root_ff[k] <= root_ff[k-1];
      end
   end

   for (genvar j = 0; j < 4; j++) begin : g_div
      fpia_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock     (clock),
         .x_in      ((j < 2) ? req_data.a_low : req_data.a_high),
         .y_in      ((j % 2 == 0) ? req_data.b_low : req_data.b_high),
         .floor_out (dfl[j]),
         .ceil_out  (dce[j]),
         .ovf_out   (dovf[j])
      );
   end

   always_ff @(posedge clock) begin
      dmn01_ff   <= ($signed(dfl[1]) < $signed(dfl[0])) ? dfl[1] : dfl[0];
      dmn23_ff   <= ($signed(dfl[3]) < $signed(dfl[2])) ? dfl[3] : dfl[2];
      dmx01_ff   <= ($signed(dce[0]) < $signed(dce[1])) ? dce[1] : dce[0];
      dmx23_ff   <= ($signed(dce[2]) < $signed(dce[3])) ? dce[3] : dce[2];
      dovf0_ff   <= dovf[0];
      dovf123_ff <= |dovf[3:1];
   end

   always_comb begin
      c_last = ctl_ff[LAT-1];
      rsp_in = '0;
      unique case (c_last.action)
         ACT_ADD, ACT_SUB, ACT_OVERLAP: begin
            rsp_in.res_low  = c_last.low;
            rsp_in.res_high = c_last.high;
            rsp_in.overlaps = c_last.overlaps;
            rsp_in.status   = c_last.status;
         end
         ACT_MUL: begin
            if (mul_ff[MUL_PAD-1].ovf) begin
               rsp_in.status = ST_OVERFLOW;
            end else begin
               rsp_in.res_low  = mul_ff[MUL_PAD-1].low;
               rsp_in.res_high = mul_ff[MUL_PAD-1].high;
            end
         end
         ACT_DIV: begin
            priority if (c_last.b_low_bad) begin
               rsp_in.status = ST_DIV_NONPOS;
            end else if (dovf0_ff) begin
               rsp_in.status = ST_OVERFLOW;
            end else if (c_last.b_high_bad) begin
               rsp_in.status = ST_DIV_NONPOS;
            end else if (dovf123_ff) begin
               rsp_in.status = ST_OVERFLOW;
            end else begin
               rsp_in.res_low  = ($signed(dmn23_ff) < $signed(dmn01_ff)) ? dmn23_ff : dmn01_ff;
               rsp_in.res_high = ($signed(dmx01_ff) < $signed(dmx23_ff)) ? dmx23_ff : dmx01_ff;
            end
         end
         ACT_SQRT: begin
            if (c_last.root_neg) begin
               rsp_in.status = ST_ROOT_NEG;
            end else begin
               rsp_in.res_low  = root_ff[SQRT_PAD-1].root_low;
               rsp_in.res_high = root_ff[SQRT_PAD-1].root_high
                                 + 64'(root_ff[SQRT_PAD-1].inexact_high);
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
